### sv/assert_macros.svh
// Assertion macros shared by the keyer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/icwk_pkg.sv
// Shared types and constants for the iambic keyer.
// No dependencies; imported by icwk_cfg, icwk_seq and iambic_cw_keyer.
package icwk_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 7;
  localparam int DOT_BASE_BITS  = 11;
  localparam int PROD_BITS      = 19;
  localparam int DASH_Q_BITS    = 14;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LETTERSPACE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POLARITY    = 3'd5;

  // keyer modes; the unused code behaves as iambic B
  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_A = 2'd1;
  localparam logic [1:0] MODE_IAMBIC_B = 2'd2;

  // reset values of the registers
  localparam logic [5:0] SPEED_RESET  = 6'd20;
  localparam logic [6:0] WEIGHT_RESET = 7'd55;

  // ceil(2^24 / 50): exact floor(x / 50) for x up to 1200 * 3 * 127 = 457200
  localparam logic [PROD_BITS-1:0] RECIP_50 = 19'd335545;
  localparam int RECIP_SHIFT = 24;

  // dot length in ticks, 1200 / speed, speed zero read as one
  localparam logic [DOT_BASE_BITS-1:0] DOT_TABLE [64] = '{
    11'd1200, 11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200, 11'd171,
    11'd150,  11'd133,  11'd120, 11'd109, 11'd100, 11'd92,  11'd85,  11'd80,
    11'd75,   11'd70,   11'd66,  11'd63,  11'd60,  11'd57,  11'd54,  11'd52,
    11'd50,   11'd48,   11'd46,  11'd44,  11'd42,  11'd41,  11'd40,  11'd38,
    11'd37,   11'd36,   11'd35,  11'd34,  11'd33,  11'd32,  11'd31,  11'd30,
    11'd30,   11'd29,   11'd28,  11'd27,  11'd27,  11'd26,  11'd26,  11'd25,
    11'd25,   11'd24,   11'd24,  11'd23,  11'd23,  11'd22,  11'd22,  11'd21,
    11'd21,   11'd21,   11'd20,  11'd20,  11'd20,  11'd19,  11'd19,  11'd19
  };

  typedef struct packed {
    logic [1:0] keyer_mode;
    logic       swap_paddles;
    logic       letter_space_on;
    logic       active_high;
  } icwk_ctrl_t;

endpackage

### sv/icwk_cfg.sv
// Configuration registers and the element length pipeline of the keyer.
// Depends on icwk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module icwk_cfg #(
  parameter int TICK_COUNT_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icwk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [icwk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output icwk_pkg::icwk_ctrl_t                ctrl,
  output logic [TICK_COUNT_BITS-1:0]          dot_ticks,
  output logic [TICK_COUNT_BITS-1:0]          dash_ticks,
  output logic [TICK_COUNT_BITS-1:0]          lspace_ticks,
  output logic                                settled
);
  import icwk_pkg::*;

  localparam logic [TICK_COUNT_BITS-1:0] TMAX = '1;
  localparam logic [1:0] HOLD_CYCLES = 2'd3;

  logic [5:0]                 wpm;
  logic [6:0]                 weight;
  logic [1:0]                 hold;
  logic [DOT_BASE_BITS-1:0]   dot_base;
  logic [DOT_BASE_BITS+1:0]   dot_x3;
  logic [DOT_BASE_BITS:0]     dot_x2;
  logic [PROD_BITS-1:0]       prod;
  logic [2*PROD_BITS-1:0]     prod_scaled;
  logic [DASH_Q_BITS-1:0]     dash_q;
  logic                       wr;
  logic                       len_wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign len_wr    = wr && (cfg_index == REG_SPEED || cfg_index == REG_WEIGHT);
  assign settled   = (hold == 2'd0);

  assign dot_base    = DOT_TABLE[wpm];
  assign dot_x2      = {dot_base, 1'b0};
  assign dot_x3      = {1'b0, dot_x2} + {2'b00, dot_base};
  assign prod_scaled = prod * RECIP_50;
  assign dash_q      = prod_scaled[RECIP_SHIFT +: DASH_Q_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      wpm       <= SPEED_RESET;
      weight    <= WEIGHT_RESET;
      ctrl      <= '{keyer_mode: MODE_IAMBIC_B, swap_paddles: 1'b0,
                     letter_space_on: 1'b0, active_high: 1'b0};
      hold      <= HOLD_CYCLES;
    end else begin
      if (wr) begin
        case (cfg_index)
          REG_SPEED:       wpm <= cfg_data[5:0];
          REG_WEIGHT:      weight <= cfg_data;
          REG_MODE:        ctrl.keyer_mode <= cfg_data[1:0];
          REG_SWAP:        ctrl.swap_paddles <= cfg_data[0];
          REG_LETTERSPACE: ctrl.letter_space_on <= cfg_data[0];
          REG_POLARITY:    ctrl.active_high <= cfg_data[0];
          default: ;
        endcase
      end
      // hold off ticks until the new lengths reach the last stage
      if (len_wr) begin
        hold <= HOLD_CYCLES;
      end else if (hold != 2'd0) begin
        hold <= hold - 2'd1;
      end
    end
  end

  // stage 1: table lookup and dot * 3 * weight; stage 2: divide by 50
  always_ff @(posedge clk) begin
    dot_ticks    <= (32'(dot_base) > 32'(TMAX)) ? TMAX : TICK_COUNT_BITS'(dot_base);
    lspace_ticks <= (32'(dot_x2) > 32'(TMAX)) ? TMAX : TICK_COUNT_BITS'(dot_x2);
    prod         <= {{(PROD_BITS-DOT_BASE_BITS-2){1'b0}}, dot_x3} *
                    {{(PROD_BITS-7){1'b0}}, weight};
    dash_ticks   <= (32'(dash_q) > 32'(TMAX)) ? TMAX : TICK_COUNT_BITS'(dash_q);
  end

  `ASSERT_RST(a_len_write_holds, clk, rst, len_wr |=> !settled, "length write did not hold")

endmodule

### sv/icwk_seq.sv
// Keyer sequencer: one phase step per tick and the result register.
// Depends on icwk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module icwk_seq #(
  parameter int TICK_COUNT_BITS = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  icwk_pkg::icwk_ctrl_t       ctrl,
  input  logic [TICK_COUNT_BITS-1:0] dot_ticks,
  input  logic [TICK_COUNT_BITS-1:0] dash_ticks,
  input  logic [TICK_COUNT_BITS-1:0] lspace_ticks,
  input  logic                       item_valid,
  input  logic                       item_left,
  input  logic                       item_right,
  output logic                       take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       key_out,
  output logic                       busy_res
);
  import icwk_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CHECK, PH_PREDOT, PH_PREDASH, PH_SENDDOT, PH_SENDDASH,
    PH_DOTDELAY, PH_DASHDELAY, PH_DOTHELD, PH_DASHHELD, PH_LETTERSPACE
  } phase_t;

  phase_t                     phase, phase_next, ph;
  logic [TICK_COUNT_BITS-1:0] tick_count, tick_count_next, target, count_inc;
  logic                       dot_mem, dot_mem_next, dash_mem, dash_mem_next;
  logic                       key_line, key_line_next;
  logic [1:0]                 prev_levels, cur;
  logic                       pl, pr, dot, dash, straight, mode_a, done;
  logic                       first, second, step;

  assign take = !out_valid || out_ready;
  assign step = item_valid && take;

  always_comb begin
    pl        = ctrl.active_high ? item_left : ~item_left;
    pr        = ctrl.active_high ? item_right : ~item_right;
    dot       = ctrl.swap_paddles ? pr : pl;
    dash      = ctrl.swap_paddles ? pl : pr;
    straight  = (ctrl.keyer_mode == MODE_STRAIGHT);
    mode_a    = (ctrl.keyer_mode == MODE_IAMBIC_A);
    cur       = {pr, pl};

    ph = phase;
    if (phase == PH_IDLE && (dot || dash || (straight && (cur != prev_levels)))) begin
      ph = PH_CHECK;
    end

    case (ph)
      PH_SENDDASH:    target = dash_ticks;
      PH_LETTERSPACE: target = lspace_ticks;
      default:        target = dot_ticks;
    endcase
    done      = (tick_count >= target);
    count_inc = tick_count + TICK_COUNT_BITS'(1);

    phase_next      = ph;
    tick_count_next = tick_count;
    dot_mem_next    = dot_mem;
    dash_mem_next   = dash_mem;
    key_line_next   = key_line;
    first           = (ph == PH_DOTHELD) ? dot : dash;
    second          = (ph == PH_DOTHELD) ? dash : dot;

    case (ph)
      PH_IDLE: ;
      PH_CHECK: begin
        if (straight && dash) begin
          key_line_next = 1'b1;
          phase_next    = PH_IDLE;
        end else if (dot) begin
          phase_next = PH_PREDOT;
        end else if (!straight && dash) begin
          phase_next = PH_PREDASH;
        end else begin
          key_line_next = 1'b0;
          phase_next    = PH_IDLE;
        end
      end
      PH_PREDOT, PH_PREDASH: begin
        dot_mem_next  = 1'b0;
        dash_mem_next = 1'b0;
        phase_next    = (ph == PH_PREDOT) ? PH_SENDDOT : PH_SENDDASH;
      end
      PH_SENDDOT: begin
        key_line_next   = !done;
        tick_count_next = done ? '0 : count_inc;
        if (done) phase_next = PH_DOTDELAY;
        if (mode_a && !dot && !dash) dash_mem_next = 1'b0;
        else if (dash) dash_mem_next = 1'b1;
      end
      PH_SENDDASH: begin
        key_line_next   = !done;
        tick_count_next = done ? '0 : count_inc;
        if (done) phase_next = PH_DASHDELAY;
        if (mode_a && !dot && !dash) dot_mem_next = 1'b0;
        else if (dot) dot_mem_next = 1'b1;
      end
      PH_DOTDELAY: begin
        tick_count_next = done ? '0 : count_inc;
        if (done) begin
          if (!dot && straight) phase_next = PH_IDLE;
          else if (dash_mem) phase_next = PH_PREDASH;
          else phase_next = PH_DOTHELD;
        end
        if (dash) dash_mem_next = 1'b1;
      end
      PH_DASHDELAY: begin
        tick_count_next = done ? '0 : count_inc;
        if (done) phase_next = dot_mem ? PH_PREDOT : PH_DASHHELD;
        if (dot) dot_mem_next = 1'b1;
      end
      PH_DOTHELD, PH_DASHHELD: begin
        if (first) begin
          phase_next = (ph == PH_DOTHELD) ? PH_PREDOT : PH_PREDASH;
        end else if (second) begin
          phase_next = (ph == PH_DOTHELD) ? PH_PREDASH : PH_PREDOT;
        end else if (ctrl.letter_space_on) begin
          dot_mem_next  = 1'b0;
          dash_mem_next = 1'b0;
          phase_next    = PH_LETTERSPACE;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_LETTERSPACE: begin
        tick_count_next = done ? '0 : count_inc;
        if (done) begin
          if (dot_mem) phase_next = PH_PREDOT;
          else if (dash_mem) phase_next = PH_PREDASH;
          else phase_next = PH_IDLE;
        end
        if (dot) dot_mem_next = 1'b1;
        if (dash) dash_mem_next = 1'b1;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      dot_mem     <= 1'b0;
      dash_mem    <= 1'b0;
      key_line    <= 1'b0;
      prev_levels <= 2'b00;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        dot_mem     <= dot_mem_next;
        dash_mem    <= dash_mem_next;
        key_line    <= key_line_next;
        prev_levels <= cur;
        key_out     <= key_line_next;
        busy_res    <= (phase_next != PH_IDLE);
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_RST(a_gap_unkeyed, clk, rst, (phase == PH_DOTDELAY || phase == PH_DASHDELAY || phase == PH_DOTHELD || phase == PH_DASHHELD || phase == PH_LETTERSPACE) |-> !key_line, "key line high in a gap phase")
  `ASSERT_RST(a_count_clear, clk, rst, (phase == PH_IDLE || phase == PH_CHECK || phase == PH_PREDOT || phase == PH_PREDASH || phase == PH_DOTHELD || phase == PH_DASHHELD) |-> (tick_count == '0), "tick counter not cleared outside timed phases")
  `ASSERT_RST(a_stall_freezes, clk, rst, out_valid && !out_ready |=> $stable(phase) && $stable(tick_count), "sequencer advanced while result stalled")

endmodule

### sv/iambic_cw_keyer.sv
// Top level of the iambic keyer: tick input register, configuration, sequencer.
// Depends on icwk_pkg, icwk_cfg and icwk_seq.
//
// One input transfer is one 1 ms tick with the raw left and right paddle levels;
// each tick yields one result (key line and busy flag). A tick is taken every
// clock cycle while the output is ready and the length pipeline has settled:
// it is held in the input register and the sequencer then steps it into the
// result register, and a stalled output holds the pipeline. After reset and
// after every write of speed or weight, in_ready stays low while the length
// pipeline (dot table lookup, dot*3*weight multiply, reciprocal multiply for
// the divide by 50) settles; other registers take effect at once.
// The configuration port is always ready; indexes past the last register are
// ignored.
module iambic_cw_keyer #(
  parameter int TICK_COUNT_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                left_level,
  input  logic                                right_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                key_out,
  output logic                                busy_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icwk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [icwk_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import icwk_pkg::*;

  icwk_ctrl_t                 ctrl;
  logic [TICK_COUNT_BITS-1:0] dot_ticks, dash_ticks, lspace_ticks;
  logic                       settled, take;
  logic                       a_valid, a_left, a_right;

  icwk_cfg #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl),
    .dot_ticks    (dot_ticks),
    .dash_ticks   (dash_ticks),
    .lspace_ticks (lspace_ticks),
    .settled      (settled)
  );

  // input register drains whenever the sequencer takes it
  assign in_ready = settled && (!a_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_left  <= left_level;
      a_right <= right_level;
    end
  end

  icwk_seq #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .dot_ticks    (dot_ticks),
    .dash_ticks   (dash_ticks),
    .lspace_ticks (lspace_ticks),
    .item_valid   (a_valid),
    .item_left    (a_left),
    .item_right   (a_right),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_out      (key_out),
    .busy_res     (busy_res)
  );

endmodule

### bench/icwk_checker.sv
// Result checker for iambic_cw_keyer: follows tick, result and register transfers,
// predicts key line and busy flag for every tick and compares them in order.
// Depends on icwk_pkg.
module icwk_checker #(
  parameter int TICK_COUNT_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                left_level,
  input  logic                                right_level,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                key_out,
  input  logic                                busy_res,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [icwk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [icwk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fails,
  output int                                  pending
);
  import icwk_pkg::*;

  localparam int TW = TICK_COUNT_BITS;
  localparam logic [TW-1:0] TICK_MAX = '1;
  localparam int unsigned DOT_UNITS = 1200;
  localparam int unsigned WEIGHT_UNIT = 50;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PRE_DOT, S_PRE_DASH, S_DOT_ON, S_DASH_ON,
    S_DOT_GAP, S_DASH_GAP, S_DOT_HELD, S_DASH_HELD, S_LETTER_GAP
  } keyer_phase_t;

  typedef struct packed {
    logic key;
    logic busy;
  } key_result_t;

  key_result_t   key_results_q[$];
  key_result_t   want;
  int            mismatch_cnt;

  logic [5:0]    spd;
  logic [6:0]    wgt;
  icwk_ctrl_t    ctrl;
  keyer_phase_t  ph;
  logic [TW-1:0] tick_cnt;
  logic [TW-1:0] dot_len;
  logic [TW-1:0] dash_len;
  logic          dot_m;
  logic          dash_m;
  logic          key_q;
  logic [1:0]    last_lv;

  function automatic logic [TW-1:0] clamp_len(int unsigned v);
    return (v > TICK_MAX) ? TICK_MAX : v[TW-1:0];
  endfunction

  function void update_lengths();
    int unsigned base;
    base = DOT_UNITS / ((spd == 0) ? 1 : spd);
    dot_len = clamp_len(base);
    dash_len = clamp_len(base * 3 * wgt / WEIGHT_UNIT);
  endfunction

  // count one tick toward target; clear and report once reached
  function bit timer_done(logic [TW-1:0] target);
    if (tick_cnt >= target) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt + 1'b1;
    return 1'b0;
  endfunction

  function void reset_state();
    spd = SPEED_RESET;
    wgt = WEIGHT_RESET;
    ctrl.keyer_mode = MODE_IAMBIC_B;
    ctrl.swap_paddles = 1'b0;
    ctrl.letter_space_on = 1'b0;
    ctrl.active_high = 1'b0;
    ph = S_IDLE;
    tick_cnt = '0;
    dot_m = 1'b0;
    dash_m = 1'b0;
    key_q = 1'b0;
    last_lv = 2'b00;
    update_lengths();
  endfunction

  function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    case (idx)
      REG_SPEED: begin
        spd = d[5:0];
        update_lengths();
      end
      REG_WEIGHT: begin
        wgt = d[6:0];
        update_lengths();
      end
      REG_MODE:        ctrl.keyer_mode = d[1:0];
      REG_SWAP:        ctrl.swap_paddles = d[0];
      REG_LETTERSPACE: ctrl.letter_space_on = d[0];
      REG_POLARITY:    ctrl.active_high = d[0];
      default: ;
    endcase
  endfunction

  function key_result_t keyer_tick(logic lraw, logic rraw);
    logic pl, pr, dot, dash, straight, mode_a, changed, first, second;
    keyer_phase_t p1, p2;
    key_result_t r;
    pl = ctrl.active_high ? lraw : !lraw;
    pr = ctrl.active_high ? rraw : !rraw;
    dot = ctrl.swap_paddles ? pr : pl;
    dash = ctrl.swap_paddles ? pl : pr;
    straight = ctrl.keyer_mode == MODE_STRAIGHT;
    mode_a = ctrl.keyer_mode == MODE_IAMBIC_A;
    changed = {pr, pl} != last_lv;
    last_lv = {pr, pl};

    if (ph == S_IDLE && (dot || dash || (straight && changed))) ph = S_CHECK;

    case (ph)
      S_IDLE: ;
      S_CHECK: begin
        if (straight) begin
          if (dash) begin
            key_q = 1'b1;
            ph = S_IDLE;
          end else if (dot) ph = S_PRE_DOT;
          else begin
            key_q = 1'b0;
            ph = S_IDLE;
          end
        end else begin
          if (dot) ph = S_PRE_DOT;
          else if (dash) ph = S_PRE_DASH;
          else begin
            key_q = 1'b0;
            ph = S_IDLE;
          end
        end
      end
      S_PRE_DOT, S_PRE_DASH: begin
        dot_m = 1'b0;
        dash_m = 1'b0;
        ph = (ph == S_PRE_DOT) ? S_DOT_ON : S_DASH_ON;
      end
      S_DOT_ON: begin
        key_q = 1'b1;
        if (timer_done(dot_len)) begin
          key_q = 1'b0;
          ph = S_DOT_GAP;
        end
        if (mode_a && !dot && !dash) dash_m = 1'b0;
        else if (dash) dash_m = 1'b1;
      end
      S_DASH_ON: begin
        key_q = 1'b1;
        if (timer_done(dash_len)) begin
          key_q = 1'b0;
          ph = S_DASH_GAP;
        end
        if (mode_a && !dot && !dash) dot_m = 1'b0;
        else if (dot) dot_m = 1'b1;
      end
      S_DOT_GAP: begin
        if (timer_done(dot_len)) begin
          if (!dot && straight) ph = S_IDLE;
          else if (dash_m) ph = S_PRE_DASH;
          else ph = S_DOT_HELD;
        end
        if (dash) dash_m = 1'b1;
      end
      S_DASH_GAP: begin
        if (timer_done(dot_len)) ph = dot_m ? S_PRE_DOT : S_DASH_HELD;
        if (dot) dot_m = 1'b1;
      end
      S_DOT_HELD, S_DASH_HELD: begin
        first = (ph == S_DOT_HELD) ? dot : dash;
        second = (ph == S_DOT_HELD) ? dash : dot;
        p1 = (ph == S_DOT_HELD) ? S_PRE_DOT : S_PRE_DASH;
        p2 = (ph == S_DOT_HELD) ? S_PRE_DASH : S_PRE_DOT;
        if (first) ph = p1;
        else if (second) ph = p2;
        else if (ctrl.letter_space_on) begin
          dot_m = 1'b0;
          dash_m = 1'b0;
          ph = S_LETTER_GAP;
        end else ph = S_IDLE;
      end
      S_LETTER_GAP: begin
        if (timer_done(clamp_len(32'd2 * dot_len))) begin
          if (dot_m) ph = S_PRE_DOT;
          else if (dash_m) ph = S_PRE_DASH;
          else ph = S_IDLE;
        end
        if (dot) dot_m = 1'b1;
        if (dash) dash_m = 1'b1;
      end
      default: ph = S_IDLE;
    endcase

    r.key = key_q;
    r.busy = ph != S_IDLE;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_state();
      key_results_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (key_results_q.size() == 0) begin
          $error("result with no tick outstanding: key_out=%0b busy_res=%0b",
                 key_out, busy_res);
          mismatch_cnt++;
        end else begin
          want = key_results_q.pop_front();
          if (key_out !== want.key) begin
            $error("key_out mismatch: expected %0b, got %0b", want.key, key_out);
            mismatch_cnt++;
          end
          if (busy_res !== want.busy) begin
            $error("busy_res mismatch: expected %0b, got %0b", want.busy, busy_res);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) key_results_q.push_back(keyer_tick(left_level, right_level));
    end
    fails <= mismatch_cnt;
    pending <= key_results_q.size();
  end

endmodule

### bench/tb_iambic_cw_keyer.sv
// Testbench top for iambic_cw_keyer: makes paddle ticks, register writes and output
// stalls, and gives the verdict. Depends on icwk_pkg, icwk_checker and the keyer RTL.
module tb_iambic_cw_keyer;
  import icwk_pkg::*;

  localparam int TICK_COUNT_BITS = 13;
  localparam int MAX_WAIT = 18;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_TICKS = 1800;
  localparam int DOT_UNITS = 1200;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic left_level = 1'b1;
  logic right_level = 1'b1;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_ready, out_valid, key_out, busy_res, cfg_ready;

  int fails, pending;
  int tx_style = 0;
  int rx_style = 0;
  int rx_hold = 0;
  int rx_draw;
  int quiet = 0;
  int n_ticks = 0;
  int n_writes = 0;
  int n_settings = 0;
  int directed_ticks;
  int dot_unit = 60;
  logic pol_now = 1'b0;

  iambic_cw_keyer #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_level(left_level), .right_level(right_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .key_out(key_out), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  icwk_checker #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_level(left_level), .right_level(right_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .key_out(key_out), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // style 0: never wait, 1: uniform waits, 2: mostly back to back
  function automatic int draw_wait(int style);
    if (style == 0) return 0;
    if (style == 1) return $urandom_range(0, MAX_WAIT);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
  endfunction

  function automatic int unit_of(logic [5:0] spd);
    return DOT_UNITS / ((spd == 0) ? 1 : spd);
  endfunction

  // result side: after each transfer, drop ready for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_hold == 1) begin
      rx_hold <= 0;
      out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      rx_draw = draw_wait(rx_style);
      if (rx_draw > 0) begin
        out_ready <= 1'b0;
        rx_hold <= rx_draw;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("iambic_cw_keyer test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_raw(logic l, logic r);
    int gap;
    gap = draw_wait(tx_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_level <= l;
    right_level <= r;
    do @(posedge clk); while (!in_ready);
    n_ticks++;
  endtask

  task automatic press(logic lp, logic rp);
    send_raw(pol_now ? lp : !lp, pol_now ? rp : !rp);
  endtask

  // hold off until every tick has its result back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
  endtask

  task automatic configure(logic [5:0] spd, logic [6:0] wgt, logic [1:0] mode,
                           logic swap, logic lsp, logic pol);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = '0;
    // unused upper data bits must be dropped by the block
    if ($urandom_range(0, 3) == 0) junk = CFG_DATA_BITS'($urandom);
    cfg_write(REG_SPEED, {junk[6], spd});
    cfg_write(REG_WEIGHT, wgt);
    cfg_write(REG_MODE, {junk[6:2], mode});
    cfg_write(REG_SWAP, {junk[6:1], swap});
    cfg_write(REG_LETTERSPACE, {junk[6:1], lsp});
    cfg_write(REG_POLARITY, {junk[6:1], pol});
    cfg_valid <= 1'b0;
    pol_now = pol;
    dot_unit = unit_of(spd);
    n_settings++;
  endtask

  task automatic random_settings();
    logic [5:0] spd;
    logic [6:0] wgt;
    logic [1:0] mode;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) spd = 6'($urandom_range(0, 1));
    else if (pick < 4) spd = 6'($urandom_range(2, 29));
    else spd = 6'($urandom_range(30, 63));
    pick = $urandom_range(0, 11);
    case (pick)
      0: wgt = 7'd0;
      1: wgt = 7'd127;
      2: wgt = 7'($urandom_range(0, 127));
      3: wgt = 7'd33;
      4: wgt = 7'd66;
      default: wgt = 7'($urandom_range(33, 66));
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       mode = MODE_UNUSED;
      1, 2:    mode = MODE_STRAIGHT;
      3, 4, 5: mode = MODE_IAMBIC_A;
      default: mode = MODE_IAMBIC_B;
    endcase
    configure(spd, wgt, mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // one paddle gesture sized to the current dot length
  task automatic play_pattern();
    int kind, len, span, k;
    logic a;
    span = (dot_unit > 40) ? 40 : dot_unit;
    len = $urandom_range(1, 4 * span);
    kind = $urandom_range(0, 11);
    a = 1'($urandom_range(0, 1));
    case (kind)
      0, 1: repeat (len) press(1'b1, 1'b0);
      2, 3: repeat (len) press(1'b0, 1'b1);
      4, 5: repeat (len) press(1'b1, 1'b1);
      6, 7: repeat ($urandom_range(1, 3 * span)) press(1'b0, 1'b0);
      8: begin
        // hold one paddle, flick the other, maybe let go of both, then resume
        k = len / 2 + 1;
        repeat (k) press(a, !a);
        repeat ($urandom_range(1, 3)) press(!a, a);
        if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) press(1'b0, 1'b0);
        repeat (k) press(a, !a);
      end
      9: repeat ($urandom_range(1, 6)) send_raw(1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)));
      default: begin
        repeat ($urandom_range(1, 2)) press(a, !a);
        repeat ($urandom_range(span, 5 * span)) press(1'b0, 1'b0);
      end
    endcase
  endtask

  initial begin
    int start, target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // straight key: dash paddle keys the line, any level change starts a check
    configure(6'd63, 7'd33, MODE_STRAIGHT, 1'b0, 1'b1, 1'b1);
    press(1'b0, 1'b1);
    press(1'b0, 1'b1);
    press(1'b0, 1'b0);
    press(1'b1, 1'b1);
    press(1'b0, 1'b0);
    press(1'b1, 1'b0);
    press(1'b1, 1'b0);
    press(1'b0, 1'b0);
    drain();

    // flip polarity with the pins held: both paddles now read pressed
    cfg_write(REG_POLARITY, '0);
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, '1);
    cfg_valid <= 1'b0;
    pol_now = 1'b0;
    send_raw(1'b0, 1'b0);
    send_raw(1'b0, 1'b0);
    send_raw(1'b1, 1'b1);
    drain();

    // start a long dot at the slowest speed, then shorten it under way
    configure(6'd1, 7'd66, MODE_IAMBIC_A, 1'b1, 1'b0, 1'b0);
    repeat (20) press(1'b0, 1'b1);
    drain();
    cfg_write(REG_SPEED, 7'd63);
    cfg_valid <= 1'b0;
    dot_unit = unit_of(6'd63);
    press(1'b0, 1'b1);
    press(1'b0, 1'b0);
    press(1'b0, 1'b0);
    drain();

    // speed zero, unused mode code, heaviest weight
    configure(6'd0, 7'd127, MODE_UNUSED, 1'b0, 1'b0, 1'b1);
    press(1'b0, 1'b1);
    press(1'b1, 1'b1);
    press(1'b0, 1'b0);
    drain();
    directed_ticks = n_ticks;

    while (n_ticks - directed_ticks < RANDOM_TICKS) begin
      drain();
      random_settings();
      tx_style = $urandom_range(0, 2);
      rx_style = $urandom_range(0, 2);
      start = n_ticks;
      target = $urandom_range(60, 140);
      while (n_ticks - start < target) begin
        play_pattern();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("covered %0d paddle ticks (%0d random) under %0d settings, %0d register writes",
             n_ticks, n_ticks - directed_ticks, n_settings, n_writes);
    if (fails == 0 && pending == 0) $display("iambic_cw_keyer test passed");
    else $display("iambic_cw_keyer test failed");
    $finish;
  end

endmodule
